// ===== design/rau_pkg.sv =====
`default_nettype none
package rau_pkg;

  localparam int OpWidth  = 32;
  localparam int NumWidth = 64;
  localparam int DenWidth = 63;

  // operation codes
  localparam logic [2:0] KIND_ADD  = 3'd0;
  localparam logic [2:0] KIND_SUB  = 3'd1;
  localparam logic [2:0] KIND_MUL  = 3'd2;
  localparam logic [2:0] KIND_DIV  = 3'd3;
  localparam logic [2:0] KIND_NEG  = 3'd4;
  localparam logic [2:0] KIND_CMP  = 3'd5;
  localparam logic [2:0] KIND_NORM = 3'd6;
  localparam logic [2:0] KIND_RSVD = 3'd7;

  // compare results
  localparam logic [1:0] ORDER_LESS    = 2'd0;
  localparam logic [1:0] ORDER_EQUAL   = 2'd1;
  localparam logic [1:0] ORDER_GREATER = 2'd2;

  typedef struct packed {
    logic [2:0]                 kind;
    logic signed [OpWidth-1:0]  a_num;
    logic signed [OpWidth-1:0]  a_den;
    logic signed [OpWidth-1:0]  b_num;
    logic signed [OpWidth-1:0]  b_den;
  } in_word_t;

  typedef struct packed {
    logic signed [NumWidth-1:0] res_num;
    logic [DenWidth-1:0]        res_den;
    logic [1:0]                 order;
    logic                       error;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_COMB,
    ST_CHECK,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MUL1,
    CMD_MUL2,
    CMD_MUL3,
    CMD_COMB,
    CMD_GCD_INIT,
    CMD_GCD_STEP,
    CMD_DIV_NUM_INIT,
    CMD_DIV_DEN_INIT,
    CMD_DIV_STEP,
    CMD_OUT
  } cmd_e;

  typedef struct packed {
    cmd_e op;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic cmp;
    logic zero;
    logic gcd_done;
    logic div_done;
  } stat_t;

endpackage
`default_nettype wire

// ===== design/rau_ctrl.sv =====
`default_nettype none
module rau_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  wire              out_stall_i,
  input  rau_pkg::stat_t   st_i,
  output rau_pkg::cmd_t    cmd_o
);
  import rau_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_MUL1;
      ST_MUL1:  state_d = st_i.err ? ST_OUT : ST_MUL2;
      ST_MUL2:  state_d = ST_MUL3;
      ST_MUL3:  state_d = ST_COMB;
      ST_COMB:  state_d = ST_CHECK;
      ST_CHECK: state_d = (st_i.cmp || st_i.zero) ? ST_OUT : ST_GCD;
      ST_GCD:   if (st_i.gcd_done) state_d = ST_DIVN;
      ST_DIVN:  if (st_i.div_done) state_d = ST_DIVD;
      ST_DIVD:  if (st_i.div_done) state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.op    = CMD_NONE;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) cmd_o.op = CMD_LOAD;
      end
      ST_MUL1:  cmd_o.op = CMD_MUL1;
      ST_MUL2:  cmd_o.op = CMD_MUL2;
      ST_MUL3:  cmd_o.op = CMD_MUL3;
      ST_COMB:  cmd_o.op = CMD_COMB;
      ST_CHECK: cmd_o.op = CMD_GCD_INIT;
      ST_GCD:   cmd_o.op = st_i.gcd_done ? CMD_DIV_NUM_INIT : CMD_GCD_STEP;
      ST_DIVN:  cmd_o.op = st_i.div_done ? CMD_DIV_DEN_INIT : CMD_DIV_STEP;
      ST_DIVD:  cmd_o.op = st_i.div_done ? CMD_NONE : CMD_DIV_STEP;
      ST_OUT: begin
        if (out_free) begin
          cmd_o.op    = CMD_OUT;
          out_valid_d = 1'b1;
        end
      end
      default: cmd_o.op = CMD_NONE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== design/rau_dp.sv =====
`default_nettype none
module rau_dp #(
  parameter int OPERAND_WIDTH = 32
) (
  input  wire                 clk_i,
  input  rau_pkg::in_word_t   in_data_i,
  input  rau_pkg::cmd_t       cmd_i,
  output rau_pkg::stat_t      st_o,
  output rau_pkg::out_word_t  out_data_o
);
  import rau_pkg::*;

  localparam int Sh = OpWidth - OPERAND_WIDTH;

  function automatic logic signed [OpWidth-1:0] sext(input logic [OpWidth-1:0] f);
    logic signed [OpWidth-1:0] t;
    t = $signed(f << Sh);
    return t >>> Sh;
  endfunction

  function automatic logic [OpWidth-1:0] mag(input logic signed [OpWidth-1:0] x);
    return x[OpWidth-1] ? OpWidth'(-x) : OpWidth'(x);
  endfunction

  // operands after sign extension
  logic signed [OpWidth-1:0] an, ad, bn, bd;
  logic                      err_in;

  logic [2:0]          kind_q;
  logic [OpWidth-1:0]  ma_q, mad_q, mb_q, mbd_q;
  logic                sa_q, sb_q, err_q;

  logic [NumWidth-1:0] p1_q, p2_q, p3_q;
  logic                neg_q, zero_q;
  logic [NumWidth-1:0] mag_q, den_q;
  logic [1:0]          order_q;

  logic [NumWidth-1:0] u_q, v_q, g_q, rem_q, dvd_q, qnum_q;
  logic [5:0]          k_q;
  logic [6:0]          cnt_q;

  logic [OpWidth-1:0]  mul_x, mul_y, p1y, p3y;
  logic [NumWidth-1:0] prod;

  logic                sb_eff;
  logic [NumWidth:0]   t1, t2, sum;
  logic                neg_d;
  logic [NumWidth-1:0] mag_d, den_d;

  logic [NumWidth:0]   trial, trial_sub;
  logic                qbit;

  out_word_t out_q;

  assign an = sext(in_data_i.a_num);
  assign ad = sext(in_data_i.a_den);
  assign bn = sext(in_data_i.b_num);
  assign bd = sext(in_data_i.b_den);

  always_comb begin
    err_in = (in_data_i.kind == KIND_RSVD) || (ad == '0);
    if ((in_data_i.kind == KIND_ADD || in_data_i.kind == KIND_SUB ||
         in_data_i.kind == KIND_MUL || in_data_i.kind == KIND_DIV ||
         in_data_i.kind == KIND_CMP) && bd == '0) err_in = 1'b1;
    if (in_data_i.kind == KIND_DIV && bn == '0) err_in = 1'b1;
  end

  // shared 32x32 multiplier
  always_comb begin
    case (kind_q)
      KIND_ADD, KIND_SUB, KIND_CMP, KIND_DIV: p1y = mbd_q;
      KIND_MUL: p1y = mb_q;
      default:  p1y = OpWidth'(1);
    endcase
    case (kind_q)
      KIND_DIV:            p3y = mb_q;
      KIND_NEG, KIND_NORM: p3y = OpWidth'(1);
      default:             p3y = mbd_q;
    endcase
    case (cmd_i.op)
      CMD_MUL1: begin mul_x = ma_q;  mul_y = p1y;   end
      CMD_MUL2: begin mul_x = mb_q;  mul_y = mad_q; end
      default:  begin mul_x = mad_q; mul_y = p3y;   end
    endcase
    prod = NumWidth'(mul_x) * NumWidth'(mul_y);
  end

  // add, sub and cmp combine scaled terms into one signed numerator; other kinds give p1 a sign
  always_comb begin
    sb_eff = sb_q ^ (kind_q == KIND_SUB || kind_q == KIND_CMP);
    t1     = {1'b0, p1_q};
    t2     = {1'b0, p2_q};
    sum    = (sa_q ? -t1 : t1) + (sb_eff ? -t2 : t2);
    den_d  = p3_q;
    case (kind_q)
      KIND_ADD, KIND_SUB, KIND_CMP: begin
        neg_d = sum[NumWidth];
        mag_d = neg_d ? NumWidth'(-sum) : sum[NumWidth-1:0];
      end
      KIND_NEG: begin
        neg_d = !sa_q;
        mag_d = p1_q;
      end
      KIND_NORM: begin
        neg_d = sa_q;
        mag_d = p1_q;
      end
      default: begin
        neg_d = sa_q ^ sb_q;
        mag_d = p1_q;
      end
    endcase
  end

  // one restoring division step
  always_comb begin
    trial     = {rem_q, dvd_q[NumWidth-1]};
    trial_sub = trial - {1'b0, g_q};
    qbit      = (trial >= {1'b0, g_q});
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_LOAD: begin
        kind_q <= in_data_i.kind;
        ma_q   <= mag(an);
        mad_q  <= mag(ad);
        mb_q   <= mag(bn);
        mbd_q  <= mag(bd);
        sa_q   <= an[OpWidth-1] ^ ad[OpWidth-1];
        sb_q   <= bn[OpWidth-1] ^ bd[OpWidth-1];
        err_q  <= err_in;
      end
      CMD_MUL1: p1_q <= prod;
      CMD_MUL2: p2_q <= prod;
      CMD_MUL3: p3_q <= prod;
      CMD_COMB: begin
        neg_q  <= neg_d;
        mag_q  <= mag_d;
        den_q  <= den_d;
        zero_q <= (mag_d == '0);
        if (neg_d)              order_q <= ORDER_LESS;
        else if (mag_d == '0)   order_q <= ORDER_EQUAL;
        else                    order_q <= ORDER_GREATER;
      end
      CMD_GCD_INIT: begin
        u_q <= mag_q;
        v_q <= den_q;
        k_q <= '0;
      end
      CMD_GCD_STEP: begin
        if (!u_q[0] && !v_q[0]) begin
          u_q <= u_q >> 1;
          v_q <= v_q >> 1;
          k_q <= k_q + 6'd1;
        end else if (!u_q[0]) begin
          u_q <= u_q >> 1;
        end else if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else if (u_q >= v_q) begin
          u_q <= (u_q - v_q) >> 1;
        end else begin
          v_q <= (v_q - u_q) >> 1;
        end
      end
      CMD_DIV_NUM_INIT: begin
        g_q   <= v_q << k_q;
        dvd_q <= mag_q;
        rem_q <= '0;
        cnt_q <= '0;
      end
      CMD_DIV_DEN_INIT: begin
        qnum_q <= dvd_q;
        dvd_q  <= den_q;
        rem_q  <= '0;
        cnt_q  <= '0;
      end
      CMD_DIV_STEP: begin
        rem_q <= qbit ? trial_sub[NumWidth-1:0] : trial[NumWidth-1:0];
        dvd_q <= {dvd_q[NumWidth-2:0], qbit};
        cnt_q <= cnt_q + 7'd1;
      end
      CMD_OUT: begin
        out_q.res_num <= '0;
        out_q.res_den <= DenWidth'(1);
        out_q.order   <= ORDER_LESS;
        out_q.error   <= err_q;
        if (!err_q && kind_q == KIND_CMP) begin
          out_q.order <= order_q;
        end else if (!err_q && !zero_q) begin
          out_q.res_num <= neg_q ? -qnum_q : qnum_q;
          out_q.res_den <= dvd_q[DenWidth-1:0];
        end
      end
      default: ;
    endcase
  end

  assign st_o.err      = err_q;
  assign st_o.cmp      = (kind_q == KIND_CMP);
  assign st_o.zero     = zero_q;
  assign st_o.gcd_done = (u_q == '0);
  assign st_o.div_done = cnt_q[6];
  assign out_data_o    = out_q;

endmodule
`default_nettype wire

// ===== design/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: add, subtract, multiply, divide, negate, compare
// and normalize of two signed fractions, with the result fully reduced.
//
// Channels: the input word (kind and two fractions) is taken when
// in_valid_i is high and in_stall_o is low; the result word leaves when
// out_valid_o is high and out_stall_i is low. One word is in work at a time.
//
// Sequence: an error result goes from ST_MUL1 to ST_OUT; compares and zero
// results pass ST_MUL1, ST_MUL2, ST_MUL3, ST_COMB and ST_CHECK. Others run a
// binary gcd loop (one shift or subtract-shift per cycle) and two 64-step
// restoring divisions on a shared divider; that loop and the divider set the
// rate. The next word can be taken in the cycle after the result is loaded.
//
// Reset clears the controller and the output valid; the block then waits
// for a word. A stalled result stays in the output register; the next word
// is still accepted and computed, and it waits at the end until the output
// register is free.
`default_nettype none
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = 32
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  rau_pkg::in_word_t   in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output rau_pkg::out_word_t  out_data_o
);
  import rau_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // sequencer: walks multiply, combine, gcd and divide steps
  rau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  // datapath: operand registers, multiplier, gcd and divider
  rau_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .st_o       (st),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire

// ===== design/rau_checker.sv =====
`default_nettype none
module rau_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 in_valid_i,
  input wire                 in_stall_o,
  input rau_pkg::in_word_t   in_data_i,
  input wire                 out_valid_o,
  input wire                 out_stall_i,
  input rau_pkg::out_word_t  out_data_o
);
  import rau_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // one word in work: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted a word while busy");

  // error results read 0/1
  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error |->
      out_data_o.res_num == '0 && out_data_o.res_den == 63'd1 &&
      out_data_o.order == ORDER_LESS)
    else $error("malformed error result");

  // denominator never zero
  a_den_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.res_den != '0)
    else $error("zero denominator in result");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);
`default_nettype wire
